/* rtl/core/assert_macros.svh */
// Assertion helpers included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never hold on a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* rtl/core/lrupr_pkg.sv */
package lrupr_pkg;

   localparam int NUM_PAGES    = 32;
   localparam int PAGE_W       = $clog2(NUM_PAGES);
   localparam int CNT_W        = PAGE_W + 1;
   localparam int FRAME_W      = 5;
   localparam int FRAMES_CFG_W = 6;
   localparam int TIME_W       = 16;
   localparam int FAULT_W      = 16;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [FRAMES_CFG_W-1:0] MAX_FRAMES    = FRAMES_CFG_W'(32);
   localparam logic [FRAMES_CFG_W-1:0] FRAMES_RESET  = FRAMES_CFG_W'(4);
   localparam logic [FRAMES_CFG_W-1:0] FRAMES_MIN    = FRAMES_CFG_W'(1);
   localparam logic [TIME_W-1:0]       TIME_MAX      = '1;
   localparam logic [FAULT_W-1:0]      FAULT_MAX     = '1;
   localparam logic                    CSR_IDX_FRAMES = 1'b0;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic [TIME_W-1:0]  stamp;
   } entry_type;

   typedef struct packed {
      logic              we;
      logic [PAGE_W-1:0] waddr;
      entry_type         wdata;
      logic [PAGE_W-1:0] raddr;
   } ram_req_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

/* rtl/core/lrupr_ram.sv */
module lrupr_ram (
   input  logic                  clock,
   input  lrupr_pkg::ram_req_type ram_req,
   output lrupr_pkg::entry_type  rd_data
);
   import lrupr_pkg::*;

   entry_type mem [NUM_PAGES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
      rd_data_ff <= mem[ram_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/lru_page_replacement.sv */
// LRU page replacement: one page access per item, one result per item. Frame and
// last-use stamp of every page sit in a 32-entry synchronous RAM; valid bits are
// flops. A hit or a miss with a free frame goes through accept, RAM lookup and commit;
// a new request is taken only once the previous item has committed.
// A miss with every frame taken scans all 32 RAM entries one per cycle for the
// oldest stamp among valid pages before its commit.
// The result sits in an output register, so the next item is taken while the
// previous result waits. No clearing pass after reset.
module lru_page_replacement (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [4:0]                        req_page_number,
   input  logic                              req_clear_first,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic [4:0]                        rsp_frame,
   output logic                              rsp_evicted,
   output logic [4:0]                        rsp_evicted_page,
   output logic [15:0]                       rsp_fault_count,
   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lrupr_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [lrupr_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [lrupr_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                              pready
);
   import lrupr_pkg::*;

   state_type                 state_ff, state_in;
   logic [NUM_PAGES-1:0]      valid_ff;
   logic [NUM_PAGES-1:0]      valid_in;
   logic [PAGE_W-1:0]         page_ff;
   logic [FRAMES_CFG_W-1:0]   frames_ff;
   logic [FRAMES_CFG_W-1:0]   next_free_ff;
   logic [TIME_W-1:0]         time_ff;
   logic [FAULT_W-1:0]        faults_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic                      found_ff;
   logic [PAGE_W-1:0]         best_page_ff;
   logic [TIME_W-1:0]         best_time_ff;
   logic [FRAME_W-1:0]        best_frame_ff;

   logic                      rsp_valid_ff;
   logic                      rsp_hit_ff;
   logic [FRAME_W-1:0]        rsp_frame_ff;
   logic                      rsp_evicted_ff;
   logic [PAGE_W-1:0]         rsp_evicted_page_ff;
   logic [FAULT_W-1:0]        rsp_fault_count_ff;

   ram_req_type               ram_req;
   entry_type                 rd_data;

   logic                      req_accept;
   logic                      cfg_write;
   logic [FRAMES_CFG_W-1:0]   frames_eff;
   logic                      has_free;
   logic                      page_hit;
   logic                      out_free;
   logic                      commit;
   logic [CNT_W-1:0]          cnt_prev;
   logic [PAGE_W-1:0]         scan_page;
   logic                      scan_take;

   logic                      res_hit;
   logic [FRAME_W-1:0]        res_frame;
   logic                      res_evicted;
   logic [PAGE_W-1:0]         res_evicted_page;
   logic [FAULT_W-1:0]        faults_in;

   lrupr_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   // register port
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && (paddr[2] == CSR_IDX_FRAMES);
   assign prdata    = (paddr[2] == CSR_IDX_FRAMES) ?
                      CSR_DATA_W'(frames_ff) : '0;

   always_comb begin
      if (frames_ff < FRAMES_MIN) begin
         frames_eff = FRAMES_MIN;
      end else if (frames_ff > MAX_FRAMES) begin
         frames_eff = MAX_FRAMES;
      end else begin
         frames_eff = frames_ff;
      end
   end

   assign has_free   = next_free_ff < frames_eff;
   assign page_hit   = valid_ff[page_ff];
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign commit     = (state_ff == ST_DONE) && out_free;

   // RAM data in SCAN is a registered read: it belongs to the entry at cnt_ff minus one
   assign cnt_prev  = cnt_ff - CNT_W'(1);
   assign scan_page = cnt_prev[PAGE_W-1:0];
   assign scan_take = (state_ff == ST_SCAN) && (cnt_ff != '0) && valid_ff[scan_page] &&
                      (!found_ff || (rd_data.stamp < best_time_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            state_in = (!page_hit && !has_free) ? ST_SCAN : ST_DONE;
         end
         ST_SCAN: begin
            if (cnt_ff == CNT_W'(NUM_PAGES)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and RAM control
   always_comb begin
      req_ready     = 1'b0;
      ram_req.raddr = page_ff;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_LOOK: ram_req.raddr = page_ff;
         ST_SCAN: ram_req.raddr = cnt_ff[PAGE_W-1:0];
         ST_DONE: ram_req.raddr = page_ff;
         default: req_ready = 1'b0;
      endcase

      res_hit          = 1'b0;
      res_evicted      = 1'b0;
      res_evicted_page = '0;
      res_frame        = next_free_ff[FRAME_W-1:0];
      if (page_hit) begin
         res_hit   = 1'b1;
         res_frame = rd_data.frame;
      end else if (!has_free && found_ff) begin
         res_frame        = best_frame_ff;
         res_evicted      = 1'b1;
         res_evicted_page = best_page_ff;
      end

      faults_in = faults_ff;
      if (!page_hit && (faults_ff != FAULT_MAX)) begin
         faults_in = faults_ff + FAULT_W'(1);
      end

      ram_req.we          = commit;
      ram_req.waddr       = page_ff;
      ram_req.wdata.frame = res_frame;
      ram_req.wdata.stamp = time_ff;
   end

   // valid bits: clear on a new run, victim out and new page in at commit
   always_comb begin
      valid_in = valid_ff;
      if (req_accept && req_clear_first) begin
         valid_in = '0;
      end
      if (commit && !page_hit) begin
         if (!has_free && found_ff) begin
            valid_in[best_page_ff] = 1'b0;
         end
         valid_in[page_ff] = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         frames_ff    <= FRAMES_RESET;
         next_free_ff <= '0;
         time_ff      <= '0;
         faults_ff    <= '0;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         if (cfg_write) begin
            frames_ff <= pwdata[FRAMES_CFG_W-1:0];
         end
         if (req_accept && req_clear_first) begin
            next_free_ff <= '0;
            time_ff      <= '0;
            faults_ff    <= '0;
         end
         if (state_ff == ST_LOOK) begin
            cnt_ff   <= '0;
            found_ff <= 1'b0;
         end
         if (state_ff == ST_SCAN) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (scan_take) found_ff <= 1'b1;
         end
         if (commit) begin
            faults_ff <= faults_in;
            if (time_ff != TIME_MAX) time_ff <= time_ff + TIME_W'(1);
            if (!page_hit && has_free) begin
               next_free_ff <= next_free_ff + FRAMES_CFG_W'(1);
            end
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         page_ff <= req_page_number[PAGE_W-1:0];
      end
      if (scan_take) begin
         best_page_ff  <= scan_page;
         best_time_ff  <= rd_data.stamp;
         best_frame_ff <= rd_data.frame;
      end
      if (commit) begin
         rsp_hit_ff          <= res_hit;
         rsp_frame_ff        <= res_frame;
         rsp_evicted_ff      <= res_evicted;
         rsp_evicted_page_ff <= res_evicted_page;
         rsp_fault_count_ff  <= faults_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_frame        = rsp_frame_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_evicted_page = rsp_evicted_page_ff;
   assign rsp_fault_count  = rsp_fault_count_ff;

endmodule

/* rtl/core/lrupr_checker.sv */
`include "assert_macros.svh"

module lrupr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_hit,
   input logic        rsp_evicted,
   input logic [4:0]  rsp_evicted_page,
   input logic [15:0] rsp_fault_count
);

   // one item at a time: no accept on the cycle after an accept
   `ASSERT_CLK(a_one_in_flight, clock, reset,
      (req_valid && req_ready) |=> !req_ready,
      "req accepted back to back")

   // a stalled result stays offered
   `ASSERT_CLK(a_rsp_hold, clock, reset,
      (rsp_valid && !rsp_ready) |=> rsp_valid,
      "rsp dropped while stalled")

   `ASSERT_NEVER(a_hit_evict, clock, reset,
      rsp_valid && rsp_hit && rsp_evicted,
      "hit reported an eviction")

   `ASSERT_NEVER(a_evict_page_zero, clock, reset,
      rsp_valid && !rsp_evicted && (rsp_evicted_page != 5'd0),
      "evicted page nonzero without eviction")

   `ASSERT_NEVER(a_fault_counted, clock, reset,
      rsp_valid && !rsp_hit && (rsp_fault_count == 16'd0),
      "fault without fault count")

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (.*);
